### design/bb3ea_pkg.sv
// bb3ea_pkg: shared types and constants of the edge-aware 3x3 box blur
// no dependencies

package bb3ea_pkg;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int CSUM_W = 10;
    localparam int SUM_W  = 12;
    localparam int NUM_W  = 13;
    localparam int PROD_W = 24;
    localparam int CFG_W  = 11;
    localparam int CRD_W  = 10;
    localparam int ODATA_W = 48;

    // neighbour count codes
    localparam logic [1:0] N_4 = 2'd0;
    localparam logic [1:0] N_6 = 2'd1;
    localparam logic [1:0] N_9 = 2'd2;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // reciprocals: floor(y/3) for y < 2048, floor(y/9) for y < 32768
    localparam logic [10:0] RCP3 = 11'd1366;
    localparam int          RCP3_SH = 12;
    localparam logic [11:0] RCP9 = 12'd3641;
    localparam int          RCP9_SH = 15;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

    typedef logic [PIX_W-1:0] t_pix;
    // per channel column sums, red in entry 0
    typedef logic [2:0][CSUM_W-1:0] t_chan_sums;
    // window column sums, leftmost column in entry 0
    typedef logic [2:0][2:0][CSUM_W-1:0] t_col_sums;
    typedef logic [2:0][SUM_W-1:0] t_win_sums;

endpackage

### design/bb3ea_ram.sv
// bb3ea_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module bb3ea_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/box_blur_3x3_edge_aware.sv
// box_blur_3x3_edge_aware: top level of the edge-aware 3x3 rgb box blur
// depends on bb3ea_pkg and bb3ea_ram
//
// Pixels enter in raster order on the slave stream, one per transfer. Each
// result carries a blurred pixel with its row and column; tlast marks the
// final result caused by one input pixel and tuser marks the bottom-right
// pixel of the frame. Row r-1 is produced while row r arrives, and the last
// row is produced interleaved with its own arrival, after the row above.
// Frame size is set through the write port (index 0 width, 1 height) while
// the block is idle; sizes are clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT.
// An input transfer passes stage b, the job register, stage e and stage f
// before its first result. An input causes 0 to 4 results and the output
// port delivers one per cycle while the receiver is ready, so the block then
// takes one pixel per cycle except where a pixel causes more than one result,
// on the last row and at row ends; the result sequencer holds the input back.
// The two previous rows live in one ram of MAX_WIDTH entries that is read
// and written back once per pixel. Reset clears the counters and pipeline
// valid flags and sets the size to 640x480; the ram is not cleared. When
// the receiver stalls, results back up through the pipeline and tready
// drops once the result sequencer is full.

module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [10:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // in_red, in_green, in_blue
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_red, out_green, out_blue, out_row, out_col, zero pad
    output logic [47:0] o_m_axis_tdata,
    // run_last
    output logic        o_m_axis_tlast,
    // frame_last
    output logic        o_m_axis_tuser
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WWX = $clog2(MAX_WIDTH + 1);
    localparam int HWX = $clog2(MAX_HEIGHT + 1);
    localparam int DW  = (WWX > bb3ea_pkg::CFG_W) ? WWX : bb3ea_pkg::CFG_W;
    localparam int HW  = (HWX > bb3ea_pkg::CFG_W) ? HWX : bb3ea_pkg::CFG_W;
    localparam int MW  = 2 * bb3ea_pkg::PIX_W;

    // configuration
    logic [bb3ea_pkg::CFG_W-1:0] r_image_width, r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bb3ea_pkg::WIDTH_RST;
            r_image_height <= bb3ea_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bb3ea_pkg::CFG_WIDTH:  r_image_width  <= i_cfg_wdata;
                bb3ea_pkg::CFG_HEIGHT: r_image_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [DW-1:0] w_raw, w_eff;
    logic [HW-1:0] h_raw, h_eff;

    always_comb begin
        w_raw = DW'(r_image_width);
        h_raw = HW'(r_image_height);
        if (w_raw < DW'(2)) begin
            w_eff = DW'(2);
        end else if (w_raw > DW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (h_raw < HW'(2)) begin
            h_eff = HW'(2);
        end else if (h_raw > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = h_raw;
        end
    end

    // handshake chain
    logic in_acc, b_adv, j_free, e_ready, f_ready, e_take;
    logic r_b_valid, r_e_valid, r_o_valid;
    logic [3:0] r_j_mask;

    assign f_ready = !r_o_valid || i_m_axis_tready;
    assign e_ready = !r_e_valid || f_ready;
    assign e_take  = e_ready && (r_j_mask != 4'd0);
    assign j_free  = (r_j_mask == 4'd0) ||
                     (e_ready && ((r_j_mask & (r_j_mask - 4'd1)) == 4'd0));
    assign b_adv   = r_b_valid && j_free;
    assign o_s_axis_tready = !r_b_valid || j_free;
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;

    // position counters
    logic [CW-1:0] r_col, n_col, c_cur, w_last;
    logic [RW-1:0] r_row, n_row, r_cur, h_last;
    logic          c_end, r_end;

    always_comb begin
        c_cur  = (DW'(r_col) >= w_eff) ? '0 : r_col;
        r_cur  = (HW'(r_row) >= h_eff) ? '0 : r_row;
        w_last = CW'(w_eff - DW'(1));
        h_last = RW'(h_eff - HW'(1));
        c_end  = (c_cur == w_last);
        r_end  = (r_cur == h_last);
        n_col  = c_end ? '0 : c_cur + CW'(1);
        n_row  = c_end ? (r_end ? '0 : r_cur + RW'(1)) : r_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage b: line store read data arrives
    logic                  r_b_top, r_b_left, r_b_c1, r_b_r1, r_b_cend, r_b_rend;
    logic [CW-1:0]         r_b_col;
    logic [RW-1:0]         r_b_row;
    bb3ea_pkg::t_pix       r_b_pix;
    logic [MW-1:0]         mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_b_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_pix  <= i_s_axis_tdata;
            r_b_col  <= c_cur;
            r_b_row  <= r_cur;
            r_b_top  <= (r_cur >= RW'(2));
            r_b_r1   <= (r_cur != '0);
            r_b_left <= (c_cur >= CW'(2));
            r_b_c1   <= (c_cur != '0);
            r_b_cend <= c_end;
            r_b_rend <= r_end;
        end
    end

    // entry holds {row r-2, row r-1} of one column; written back shifted
    bb3ea_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (b_adv),
        .i_waddr (r_b_col),
        .i_wdata ({mem_rdata[bb3ea_pkg::PIX_W-1:0], r_b_pix}),
        .i_re    (in_acc),
        .i_raddr (c_cur),
        .o_rdata (mem_rdata)
    );

    // column sums of the new column
    bb3ea_pkg::t_chan_sums new_top, new_bot;
    bb3ea_pkg::t_chan_sums r_wa_top, r_wa_bot, r_wb_top, r_wb_bot;
    bb3ea_pkg::t_pix       old_pix, prev_pix;

    always_comb begin
        old_pix  = mem_rdata[MW-1:bb3ea_pkg::PIX_W];
        prev_pix = mem_rdata[bb3ea_pkg::PIX_W-1:0];
        for (int ch = 0; ch < 3; ch++) begin
            new_bot[ch] = bb3ea_pkg::CSUM_W'(prev_pix[ch*bb3ea_pkg::CH_W +: bb3ea_pkg::CH_W])
                        + bb3ea_pkg::CSUM_W'(r_b_pix[ch*bb3ea_pkg::CH_W +: bb3ea_pkg::CH_W]);
            new_top[ch] = new_bot[ch] + (r_b_top ?
                bb3ea_pkg::CSUM_W'(old_pix[ch*bb3ea_pkg::CH_W +: bb3ea_pkg::CH_W]) :
                bb3ea_pkg::CSUM_W'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_wa_top <= r_wb_top;
            r_wa_bot <= r_wb_bot;
            r_wb_top <= new_top;
            r_wb_bot <= new_bot;
        end
    end

    // job register: the up to four results of one pixel
    bb3ea_pkg::t_col_sums r_j_top, r_j_bot;
    logic                 r_j_left, r_j_rtop;
    logic [CW-1:0]        r_j_col;
    logic [RW-1:0]        r_j_row;
    logic [3:0]           sel;

    assign sel = r_j_mask & (~r_j_mask + 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_mask <= 4'd0;
        end else if (b_adv) begin
            r_j_mask <= {r_b_rend && r_b_cend, r_b_rend && r_b_c1,
                         r_b_r1 && r_b_cend, r_b_r1 && r_b_c1};
        end else if (e_take) begin
            r_j_mask <= r_j_mask & ~sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_j_top  <= {new_top, r_wb_top, r_wa_top};
            r_j_bot  <= {new_bot, r_wb_bot, r_wa_bot};
            r_j_left <= r_b_left;
            r_j_rtop <= r_b_top;
            r_j_col  <= r_b_col;
            r_j_row  <= r_b_row;
        end
    end

    // stage e: window sums of the selected result
    logic                    is_low, is_end, use_a, three_r;
    bb3ea_pkg::t_col_sums    src;
    bb3ea_pkg::t_win_sums    e_sum, r_e_sum;
    logic [1:0]              e_n, r_e_n;
    logic [bb3ea_pkg::CRD_W-1:0] e_row, e_col, r_e_row, r_e_col;
    logic                    r_e_last, r_e_flast;

    always_comb begin
        is_low  = sel[2] || sel[3];
        is_end  = sel[1] || sel[3];
        use_a   = !is_end && r_j_left;
        three_r = !is_low && r_j_rtop;
        src     = is_low ? r_j_bot : r_j_top;
        for (int ch = 0; ch < 3; ch++) begin
            e_sum[ch] = bb3ea_pkg::SUM_W'(src[1][ch]) + bb3ea_pkg::SUM_W'(src[2][ch])
                      + (use_a ? bb3ea_pkg::SUM_W'(src[0][ch]) : bb3ea_pkg::SUM_W'(0));
        end
        if (use_a && three_r) begin
            e_n = bb3ea_pkg::N_9;
        end else if (use_a || three_r) begin
            e_n = bb3ea_pkg::N_6;
        end else begin
            e_n = bb3ea_pkg::N_4;
        end
        e_row = is_low ? bb3ea_pkg::CRD_W'(r_j_row) : bb3ea_pkg::CRD_W'(r_j_row - RW'(1));
        e_col = is_end ? bb3ea_pkg::CRD_W'(r_j_col) : bb3ea_pkg::CRD_W'(r_j_col - CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (e_ready) begin
            r_e_valid <= e_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_take) begin
            r_e_sum   <= e_sum;
            r_e_n     <= e_n;
            r_e_row   <= e_row;
            r_e_col   <= e_col;
            r_e_last  <= ((r_j_mask & ~sel) == 4'd0);
            r_e_flast <= sel[3];
        end
    end

    // stage f: rounded average, (2*sum + n) / (2*n)
    logic [bb3ea_pkg::NUM_W-1:0]  num;
    logic [bb3ea_pkg::PROD_W-1:0] prod;
    logic [2:0][bb3ea_pkg::CH_W-1:0] avg;
    logic [bb3ea_pkg::CH_W-1:0]  r_o_red, r_o_green, r_o_blue;
    logic [bb3ea_pkg::CRD_W-1:0] r_o_row, r_o_col;
    logic                        r_o_last, r_o_flast;

    always_comb begin
        num  = '0;
        prod = '0;
        for (int ch = 0; ch < 3; ch++) begin
            unique case (r_e_n)
                bb3ea_pkg::N_4: begin
                    num     = {r_e_sum[ch], 1'b0} + bb3ea_pkg::NUM_W'(4);
                    prod    = '0;
                    avg[ch] = num[3 +: bb3ea_pkg::CH_W];
                end
                bb3ea_pkg::N_6: begin
                    num     = {r_e_sum[ch], 1'b0} + bb3ea_pkg::NUM_W'(6);
                    prod    = bb3ea_pkg::PROD_W'(num[bb3ea_pkg::NUM_W-1:2])
                            * bb3ea_pkg::PROD_W'(bb3ea_pkg::RCP3);
                    avg[ch] = prod[bb3ea_pkg::RCP3_SH +: bb3ea_pkg::CH_W];
                end
                bb3ea_pkg::N_9: begin
                    num     = {r_e_sum[ch], 1'b0} + bb3ea_pkg::NUM_W'(9);
                    prod    = bb3ea_pkg::PROD_W'(num[bb3ea_pkg::NUM_W-1:1])
                            * bb3ea_pkg::PROD_W'(bb3ea_pkg::RCP9);
                    avg[ch] = prod[bb3ea_pkg::RCP9_SH +: bb3ea_pkg::CH_W];
                end
                default: begin
                    num     = '0;
                    prod    = '0;
                    avg[ch] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (f_ready) begin
            r_o_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_ready && r_e_valid) begin
            r_o_red   <= avg[0];
            r_o_green <= avg[1];
            r_o_blue  <= avg[2];
            r_o_row   <= r_e_row;
            r_o_col   <= r_e_col;
            r_o_last  <= r_e_last;
            r_o_flast <= r_e_flast;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {4'd0, r_o_col, r_o_row, r_o_blue, r_o_green, r_o_red};
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = r_o_flast;

endmodule

### verif/box_blur_3x3_edge_aware_tb.sv
// box_blur_3x3_edge_aware_tb: self-checking testbench of the edge-aware 3x3 box blur
// drives whole frames of pixels and checks each result against an in-bench predictor
// depends on bb3ea_pkg and the box_blur_3x3_edge_aware top level

module box_blur_3x3_edge_aware_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] row;
        logic [9:0] col;
        logic       run_last;
        logic       frame_last;
    } t_blur_res;

    class blur_scoreboard;
        t_blur_res  blurred_q[$];
        logic [23:0] rows_kept[3][1024];
        int width_in_use;
        int height_in_use;
        int cur_row;
        int cur_col;
        int mismatches;
        int results_seen;

        function void set_size(int w, int h);
            width_in_use  = (w < 2) ? 2 : ((w > 1024) ? 1024 : w);
            height_in_use = (h < 2) ? 2 : ((h > 1024) ? 1024 : h);
        endfunction

        function t_blur_res average_at(int orow, int ocol);
            t_blur_res res;
            int sr, sg, sb, n;
            logic [23:0] p;
            sr = 0; sg = 0; sb = 0; n = 0;
            for (int rr = orow - 1; rr <= orow + 1; rr++) begin
                for (int cc = ocol - 1; cc <= ocol + 1; cc++) begin
                    if (rr >= 0 && rr < height_in_use && cc >= 0 && cc < width_in_use) begin
                        p = rows_kept[rr % 3][cc];
                        sr += p[7:0];
                        sg += p[15:8];
                        sb += p[23:16];
                        n++;
                    end
                end
            end
            res.red        = 8'((2 * sr + n) / (2 * n));
            res.green      = 8'((2 * sg + n) / (2 * n));
            res.blue       = 8'((2 * sb + n) / (2 * n));
            res.row        = 10'(orow);
            res.col        = 10'(ocol);
            res.run_last   = 1'b0;
            res.frame_last = (orow == height_in_use - 1 && ocol == width_in_use - 1);
            return res;
        endfunction

        function void note_input(logic [23:0] pix);
            t_blur_res batch[$];
            int r, c, w, h;
            w = width_in_use;
            h = height_in_use;
            if (cur_col >= w) cur_col = 0;
            if (cur_row >= h) cur_row = 0;
            r = cur_row;
            c = cur_col;
            rows_kept[r % 3][c] = pix;
            if (r >= 1) begin
                if (c >= 1) batch.push_back(average_at(r - 1, c - 1));
                if (c == w - 1) batch.push_back(average_at(r - 1, w - 1));
            end
            if (r == h - 1) begin
                if (c >= 1) batch.push_back(average_at(r, c - 1));
                if (c == w - 1) batch.push_back(average_at(r, w - 1));
            end
            if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
            foreach (batch[i]) blurred_q.push_back(batch[i]);
            if (c == w - 1) begin
                cur_col = 0;
                cur_row = (r == h - 1) ? 0 : r + 1;
            end else begin
                cur_col = c + 1;
            end
        endfunction

        function void check_result(logic [47:0] data, logic last, logic user);
            t_blur_res exp_r;
            results_seen++;
            if (blurred_q.size() == 0) begin
                $error("result with nothing expected: tdata %h", data);
                mismatches++;
                return;
            end
            exp_r = blurred_q.pop_front();
            if (data[7:0] !== exp_r.red) begin
                $error("out_red expected %0d actual %0d", exp_r.red, data[7:0]);
                mismatches++;
            end
            if (data[15:8] !== exp_r.green) begin
                $error("out_green expected %0d actual %0d", exp_r.green, data[15:8]);
                mismatches++;
            end
            if (data[23:16] !== exp_r.blue) begin
                $error("out_blue expected %0d actual %0d", exp_r.blue, data[23:16]);
                mismatches++;
            end
            if (data[33:24] !== exp_r.row) begin
                $error("out_row expected %0d actual %0d", exp_r.row, data[33:24]);
                mismatches++;
            end
            if (data[43:34] !== exp_r.col) begin
                $error("out_col expected %0d actual %0d", exp_r.col, data[43:34]);
                mismatches++;
            end
            if (last !== exp_r.run_last) begin
                $error("run_last expected %0d actual %0d", exp_r.run_last, last);
                mismatches++;
            end
            if (user !== exp_r.frame_last) begin
                $error("frame_last expected %0d actual %0d", exp_r.frame_last, user);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [10:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        o_m_axis_tuser;

    blur_scoreboard sb;
    bit no_idle;
    int hold_off_req;
    int pixels_sent;

    box_blur_3x3_edge_aware dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int stall_cnt;
        stall_cnt = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_m_axis_tready && o_m_axis_tvalid)
                sb.check_result(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
            if (hold_off_req > 0) begin
                stall_cnt = hold_off_req;
                hold_off_req = 0;
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                i_m_axis_tready <= 1'b0;
            end else begin
                stall_cnt = pick_gap();
                i_m_axis_tready <= (stall_cnt == 0);
            end
        end
    end

    task automatic write_reg(logic idx, int value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value[10:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(int w, int h);
        write_reg(bb3ea_pkg::CFG_WIDTH, w);
        write_reg(bb3ea_pkg::CFG_HEIGHT, h);
        sb.set_size(w[10:0], h[10:0]);
    endtask

    task automatic send_pixel(logic [23:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pix;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_input(pix);
        pixels_sent++;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.blurred_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic random_frame(int n_px);
        logic [23:0] pix;
        for (int i = 0; i < n_px; i++) begin
            if ($urandom_range(0, 7) == 0)
                pix = $urandom_range(0, 1) ? 24'hffffff : 24'h000000;
            else
                pix = 24'($urandom);
            send_pixel(pix);
        end
    endtask

    initial begin
        int w, h, rnd_px;
        sb = new();
        sb.set_size(640, 480);
        no_idle = 1'b0;
        hold_off_req = 0;
        pixels_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = bb3ea_pkg::CFG_WIDTH;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frame, sizes below range clamp to 2
        set_frame(0, 1);
        send_pixel(24'h000000);
        send_pixel(24'hffffff);
        send_pixel(24'hff00ff);
        send_pixel(24'h00ff00);
        drain();

        set_frame(3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 24'hffffff : {8'h01, 8'h80, 8'hfe});
        drain();

        // long output hold-off while pixels keep coming
        set_frame(8, 4);
        hold_off_req = 300;
        random_frame(32);
        drain();

        rnd_px = 0;
        while (rnd_px < 45) begin
            w = $urandom_range(2, 6);
            h = $urandom_range(2, 4);
            set_frame(w, h);
            random_frame(w * h);
            rnd_px += w * h;
            drain();
        end

        // back-to-back pixels with no sender gaps
        no_idle = 1'b1;
        set_frame(5, 3);
        random_frame(15);
        drain();

        $display("covered %0d pixels in small frames from 2x2 to 8x4, %0d results",
                 pixels_sent, sb.results_seen);
        $display("random stalls on both sides, one long output hold-off and idle resizes");
        if (sb.mismatches == 0)
            $display("PASS box_blur_3x3_edge_aware");
        else
            $display("FAIL box_blur_3x3_edge_aware");
        $finish;
    end

    initial begin
        #8ms;
        $display("FAIL box_blur_3x3_edge_aware");
        $finish;
    end

endmodule
